@@ sv/arpt_pkg.sv @@
// Package for the ARP address table: field widths, command codes and the search word type.
`default_nettype none
package arpt_pkg;

    localparam int MAC_W       = 48;
    localparam int IP_W        = 32;
    localparam int CMD_W       = 2;
    localparam int S_TDATA_W   = 80;
    localparam int S_TUSER_W   = 8;
    localparam int M_TDATA_W   = 80;
    localparam int M_TUSER_W   = 8;

    localparam logic [CMD_W-1:0] CMD_UPDATE     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOOKUP_MAC = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOOKUP_IP  = 2'd2;

    // Search word that travels down the row of slots, one slot per cycle.
    typedef struct packed {
        logic             valid;
        logic [CMD_W-1:0] cmd;
        logic [MAC_W-1:0] mac;
        logic [IP_W-1:0]  ip;
        logic             found;
        logic [IP_W-1:0]  ip_res;
        logic [MAC_W-1:0] mac_res;
    } token_t;

    // Write of a new pair into one slot.
    typedef struct packed {
        logic             en;
        logic [MAC_W-1:0] mac;
        logic [IP_W-1:0]  ip;
    } slot_wr_t;

endpackage
`default_nettype wire

@@ sv/arp_address_table.sv @@
// Top level of the ARP address table: input register, row of slots, result stage.
//
// The table pairs 48-bit hardware addresses with 32-bit IPv4 addresses in
// ENTRIES slots that fill in order of arrival. The input stream carries one
// command word: s_tuser holds the command (0 update, 1 look up IP by
// hardware address, 2 look up hardware address by IP), s_tdata the
// hardware address and the IP. The output stream returns one word per
// command with the hit, inserted and table_full flags in m_tuser and the
// found IP and hardware address in m_tdata (zero where not found).
// A command travels down the row of slots one slot per cycle, so the lowest
// matching slot answers first; a new pair is written into the next free slot
// after the word leaves the row. A new word is taken only once the previous
// one has left the row and the holding stage, also while the last result
// still waits on m_tready; a result passes the input register, each slot
// register, the holding stage and the output register. A stalled receiver
// holds the result and then back-pressures the input.
// Reset (aresetn low, synchronous) empties the table by clearing the fill
// count; slot contents are not cleared and are never read at or above the count.
`default_nettype none
module arp_address_table #(
    parameter int ENTRIES = 16
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output      logic                           s_tready,
    // s_tdata from bit 0: mac_addr[47:0], ip_addr[31:0]
    input  wire logic [arpt_pkg::S_TDATA_W-1:0] s_tdata,
    // s_tuser from bit 0: cmd[1:0], zero fill
    input  wire logic [arpt_pkg::S_TUSER_W-1:0] s_tuser,
    output      logic                           m_tvalid,
    input  wire logic                           m_tready,
    // m_tdata from bit 0: ip_out[31:0], mac_out[47:0]
    output      logic [arpt_pkg::M_TDATA_W-1:0] m_tdata,
    // m_tuser from bit 0: hit, inserted, table_full, zero fill
    output      logic [arpt_pkg::M_TUSER_W-1:0] m_tuser
);
    import arpt_pkg::*;

    localparam int CW = $clog2(ENTRIES + 1);

    token_t          tok [ENTRIES+1];
    token_t          tok0_reg;
    token_t          exit_reg;
    logic            exit_valid_reg;
    logic            inflight_reg;
    logic [CW-1:0]   count_reg;
    logic            m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [M_TUSER_W-1:0] m_tuser_reg;

    logic            accept;
    logic            out_free;
    logic            move;
    logic            is_new;
    logic            has_room;
    logic            ins_fire;
    logic            full_fire;

    // Ready whenever no search is in the row and no finished one waits.
    assign s_tready = !inflight_reg && !exit_valid_reg;
    assign accept   = s_tvalid && s_tready;

    assign out_free  = !m_tvalid_reg || m_tready;
    assign move      = exit_valid_reg && out_free;
    assign is_new    = (exit_reg.cmd == CMD_UPDATE) && !exit_reg.found;
    assign has_room  = count_reg < CW'(ENTRIES);
    assign ins_fire  = move && is_new && has_room;
    assign full_fire = is_new && !has_room;

    // Input register feeding the first slot.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok0_reg.valid <= 1'b0;
        end else begin
            tok0_reg.valid <= accept;
            if (accept) begin
                tok0_reg.cmd     <= s_tuser[CMD_W-1:0];
                tok0_reg.mac     <= s_tdata[MAC_W-1:0];
                tok0_reg.ip      <= s_tdata[MAC_W+IP_W-1:MAC_W];
                tok0_reg.found   <= 1'b0;
                tok0_reg.ip_res  <= '0;
                tok0_reg.mac_res <= '0;
            end
        end
    end

    assign tok[0] = tok0_reg;

    // The row of slots. Slots below the fill count take part in the search;
    // an insert writes the slot that the count points at.
    for (genvar i = 0; i < ENTRIES; i++) begin : g_slot
        logic     slot_valid;
        slot_wr_t wr;

        assign slot_valid = CW'(i) < count_reg;
        assign wr.en      = ins_fire && (count_reg == CW'(i));
        assign wr.mac     = exit_reg.mac;
        assign wr.ip      = exit_reg.ip;

        arpt_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .slot_valid(slot_valid),
            .wr        (wr),
            .tok_in    (tok[i]),
            .tok_out   (tok[i+1])
        );
    end

    // Control: one search in flight, then a holding stage before the output.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg   <= 1'b0;
            exit_valid_reg <= 1'b0;
            count_reg      <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (accept) begin
                inflight_reg <= 1'b1;
            end else if (tok[ENTRIES].valid) begin
                inflight_reg <= 1'b0;
            end

            if (tok[ENTRIES].valid) begin
                exit_valid_reg <= 1'b1;
            end else if (move) begin
                exit_valid_reg <= 1'b0;
            end

            if (ins_fire) begin
                count_reg <= count_reg + CW'(1);
            end

            if (move) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload of the holding and output stages needs no reset.
    always_ff @(posedge aclk) begin
        if (tok[ENTRIES].valid) begin
            exit_reg <= tok[ENTRIES];
        end
        if (move) begin
            m_tdata_reg <= {exit_reg.mac_res, exit_reg.ip_res};
            m_tuser_reg <= {{(M_TUSER_W-3){1'b0}}, full_fire,
                            is_new && has_room, exit_reg.found};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
`default_nettype wire

@@ sv/arpt_cell.sv @@
// One table slot: holds a hardware/IP pair and compares it against the passing search word.
`default_nettype none
module arpt_cell (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              slot_valid,
    input  wire arpt_pkg::slot_wr_t wr,
    input  wire arpt_pkg::token_t  tok_in,
    output arpt_pkg::token_t       tok_out
);
    import arpt_pkg::*;

    logic [MAC_W-1:0] mac_reg;
    logic [IP_W-1:0]  ip_reg;
    token_t           tok_reg;
    token_t           tok_next;
    logic             match_mac;
    logic             match_ip;
    logic             ovw;

    assign match_mac = slot_valid && (mac_reg == tok_in.mac);
    assign match_ip  = slot_valid && (ip_reg == tok_in.ip);

    // A slot only answers if no lower slot has answered already.
    always_comb begin
        tok_next = tok_in;
        ovw      = 1'b0;
        if (tok_in.valid && !tok_in.found) begin
            unique case (tok_in.cmd)
                CMD_UPDATE: begin
                    if (match_mac) begin
                        tok_next.found = 1'b1;
                        ovw            = 1'b1;
                    end
                end
                CMD_LOOKUP_MAC: begin
                    if (match_mac) begin
                        tok_next.found  = 1'b1;
                        tok_next.ip_res = ip_reg;
                    end
                end
                CMD_LOOKUP_IP: begin
                    if (match_ip) begin
                        tok_next.found   = 1'b1;
                        tok_next.mac_res = mac_reg;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mac_reg <= wr.mac;
            ip_reg  <= wr.ip;
        end else if (ovw) begin
            ip_reg <= tok_in.ip;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.valid <= 1'b0;
        end else begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule
`default_nettype wire
